// File: hw/rtl/mtce_pkg.sv
// Shared types and constants for the MIDI tempo clock engine.
package mtce_pkg;

   localparam int unsigned PULSES_PER_BEAT_N = 24;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [21:0] PERIOD_RESET = 22'd20833;
   // ceil(2^37 / 100): (x * RECIP_100) >> 37 is x / 100 for any 32-bit x
   localparam logic [31:0] RECIP_100 = 32'h51EB_851F;

   typedef enum logic [2:0] {
      ACT_TICK  = 3'd0,
      ACT_EXT   = 3'd1,
      ACT_START = 3'd2,
      ACT_STOP  = 3'd3,
      ACT_CONT  = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      MSG_NONE  = 3'd0,
      MSG_CLOCK = 3'd1,
      MSG_START = 3'd2,
      MSG_STOP  = 3'd3,
      MSG_CONT  = 3'd4
   } message_type;

   typedef enum logic [2:0] {
      MODE_IGNORE   = 3'd0,
      MODE_USE      = 3'd1,
      MODE_CONSUME  = 3'd2,
      MODE_GENERATE = 3'd3,
      MODE_BLOCK    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CSR_MODE    = 3'd0,
      CSR_BYPASS  = 3'd1,
      CSR_PERIOD  = 3'd2,
      CSR_SPEED   = 3'd3,
      CSR_SWING   = 3'd4,
      CSR_DIVISOR = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  clock_mode;
      logic        bypass_on;
      logic [21:0] pulse_period_us;
      logic [3:0]  note_speed;
      logic [6:0]  swing_percent;
      logic [7:0]  clock_divisor;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        is_tick;
      logic        is_ext;
      logic        is_start;
      logic        is_stop;
      logic        is_cont;
      logic        button;
      logic [31:0] now_us;
   } job_type;

   typedef struct packed {
      logic        pulse_flag;
      logic        note_pulse_flag;
      logic        beat_flag;
      logic [2:0]  send_message;
      logic        accepted;
      logic        run_state;
      logic [31:0] period_estimate_us;
   } rsp_type;

   function automatic logic [7:0] note_rate(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0: r = 8'd1;    4'd1: r = 8'd2;    4'd2: r = 8'd3;    4'd3: r = 8'd4;
         4'd4: r = 8'd6;    4'd5: r = 8'd8;    4'd6: r = 8'd12;   4'd7: r = 8'd24;
         4'd8: r = 8'd32;   4'd9: r = 8'd36;   4'd10: r = 8'd48;  4'd11: r = 8'd64;
         4'd12: r = 8'd72;  4'd13: r = 8'd96;  4'd14: r = 8'd144;
         default: r = 8'd192;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/mtce_req_if.sv
// Valid/ready channel interfaces for requests and responses.
interface mtce_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [31:0] now_us;
   logic       from_button;
   modport source (output valid, action, now_us, from_button, input ready);
   modport sink   (input valid, action, now_us, from_button, output ready);
endinterface

interface mtce_rsp_if;
   logic        valid;
   logic        ready;
   logic        pulse_flag;
   logic        note_pulse_flag;
   logic        beat_flag;
   logic [2:0]  send_message;
   logic        accepted;
   logic        run_state;
   logic [31:0] period_estimate_us;
   modport source (output valid, pulse_flag, note_pulse_flag, beat_flag, send_message,
                   accepted, run_state, period_estimate_us, input ready);
   modport sink   (input valid, pulse_flag, note_pulse_flag, beat_flag, send_message,
                   accepted, run_state, period_estimate_us, output ready);
endinterface

// File: hw/rtl/mtce_front.sv
// Front end: request decode and a two-entry job queue.
module mtce_front import mtce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  logic [2:0] in_action,
   input  logic [31:0] in_now_us,
   input  logic    in_button,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job
);
   job_type    q_ff [QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   job_type    dec;
   logic       push, pop;

   always_comb begin
      dec.is_tick  = in_action == ACT_TICK;
      dec.is_ext   = in_action == ACT_EXT;
      dec.is_start = in_action == ACT_START;
      dec.is_stop  = in_action == ACT_STOP;
      dec.is_cont  = in_action == ACT_CONT;
      dec.button   = in_button;
      dec.now_us   = in_now_us;
   end

   assign in_ready  = cnt_ff != 2'(QUEUE_DEPTH);
   assign push      = in_valid && in_ready;
   assign job_valid = cnt_ff != 2'd0;
   assign pop       = job_valid && job_ready;
   assign job       = q_ff[rp_ff];
   assign wp_in     = push ? ~wp_ff : wp_ff;
   assign rp_in     = pop ? ~rp_ff : rp_ff;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= dec;
   end
endmodule

// File: hw/rtl/mtce_back.sv
// Back end: tempo state, swing multiply sequence and output register.
module mtce_back import mtce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_MUL1 = 5'b00010, S_MUL2 = 5'b00100, S_MUL3 = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type st_ff, st_in;
   logic [31:0] target_ff, target_in, due_ff, due_in, last_ff, last_in, eper_ff, eper_in;
   logic [7:0]  note_ff, note_in, div_ff, div_in;
   logic [6:0]  beat_ff, beat_in;
   logic phase_ff, phase_in, armed_ff, armed_in, seen_ff, seen_in, meas_ff, meas_in;
   logic run_ff, run_in, pend_ff, pend_in;
   rsp_type rsp_ff, rsp_in;
   logic    ov_ff, ov_in;
   // delay = k * per / 100 = k * (per / 100) + (k * (per % 100)) / 100
   logic [14:0] k_ff, k_in;     // rate * percent
   logic [31:0] per_ff, per_in;
   logic [26:0] qp_ff, qp_in;   // per / 100
   logic [31:0] kq_ff, kq_in;   // k * (per / 100), low 32 bits
   logic [21:0] z_ff, z_in;     // k * (per % 100)
   logic [31:0] now_ff, now_in;

   logic ext, start_job;
   logic [31:0] per_est, d;
   logic [7:0] rate;
   logic [63:0] qp_prod, t_prod;
   logic [31:0] rp_full;
   logic [41:0] kq_full;

   assign ext       = cfg.clock_mode == MODE_USE || cfg.clock_mode == MODE_CONSUME;
   assign per_est   = meas_ff ? eper_ff : {10'd0, cfg.pulse_period_us};
   assign rate      = note_rate(cfg.note_speed);
   assign job_ready = st_ff == S_IDLE && !(ov_ff && !out_ready);
   assign start_job = job_valid && job_ready;
   assign d         = job.now_us - target_ff;
   assign qp_prod   = 64'(per_ff) * 64'(RECIP_100);
   assign rp_full   = per_ff - 32'(qp_ff) * 32'd100;
   assign kq_full   = 42'(k_ff) * 42'(qp_ff);
   assign t_prod    = 64'(z_ff) * 64'(RECIP_100);
   assign out_valid = ov_ff;
   assign out       = rsp_ff;

   always_comb begin
      logic take, swing_go, sw_idx;
      logic [7:0] nc, dc;
      logic [6:0] bc;
      logic [31:0] now;
      st_in = st_ff; target_in = target_ff; due_in = due_ff; last_in = last_ff;
      eper_in = eper_ff; note_in = note_ff; div_in = div_ff; beat_in = beat_ff;
      phase_in = phase_ff; armed_in = armed_ff; seen_in = seen_ff; meas_in = meas_ff;
      run_in = run_ff; pend_in = pend_ff; rsp_in = rsp_ff; ov_in = ov_ff;
      k_in = k_ff; per_in = per_ff; qp_in = qp_ff; kq_in = kq_ff; z_in = z_ff;
      now_in = now_ff;
      take = 1'b0; swing_go = 1'b0; nc = '0; dc = '0; bc = '0;
      now = job.now_us;
      sw_idx = cfg.note_speed inside {4'd2, 4'd4, 4'd6, 4'd7, 4'd10};
      if (ov_ff && out_ready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (start_job) begin
               rsp_in = '0;
               st_in  = S_DONE;
               if (job.is_tick) begin
                  if (!ext && d != 32'd0 && !d[31]) begin
                     target_in = target_ff + {10'd0, cfg.pulse_period_us};
                     take = 1'b1;
                  end
               end else if (job.is_ext) begin
                  take = ext;
               end else if (job.is_start) begin
                  if (!(job.button && (ext || run_ff))) begin
                     rsp_in.send_message = MSG_START;
                     div_in = 8'd1; note_in = 8'd1; beat_in = 7'd1;
                     run_in = 1'b1; phase_in = 1'b0; rsp_in.accepted = 1'b1;
                  end
               end else if (job.is_stop) begin
                  if (!(job.button && (ext || !run_ff))) begin
                     rsp_in.send_message = MSG_STOP;
                     last_in = '0; seen_in = 1'b0; eper_in = '0; meas_in = 1'b0;
                     run_in = 1'b0; rsp_in.accepted = 1'b1;
                  end
               end else if (job.is_cont) begin
                  if (!(job.button && ext) && !run_ff) begin
                     rsp_in.send_message = MSG_CONT;
                     run_in = 1'b1; rsp_in.accepted = 1'b1;
                  end
               end
               // message gating for start/stop/continue
               if (cfg.bypass_on || !(cfg.clock_mode == MODE_GENERATE ||
                   ((cfg.clock_mode == MODE_IGNORE || cfg.clock_mode == MODE_USE)
                    && !job.button)))
                  rsp_in.send_message = MSG_NONE;
               if (take && run_ff) begin
                  rsp_in.accepted = 1'b1;
                  pend_in = 1'b1;
                  if (ext) begin
                     if (seen_ff) begin
                        eper_in = now - last_ff; meas_in = 1'b1;
                     end
                     last_in = now; seen_in = 1'b1;
                  end
               end
               if (job.is_tick) begin
                  if (armed_ff && !(now - due_ff >= 32'h8000_0000)) begin
                     rsp_in.note_pulse_flag = 1'b1; armed_in = 1'b0;
                  end
                  if (pend_in) begin
                     pend_in = 1'b0;
                     rsp_in.pulse_flag = 1'b1;
                     nc = note_ff - 8'd1;
                     note_in = nc;
                     if (nc == 8'd0) begin
                        if (phase_ff && cfg.swing_percent != 7'd0) begin
                           swing_go = 1'b1;
                        end else begin
                           rsp_in.note_pulse_flag = 1'b1; armed_in = 1'b0;
                        end
                        note_in  = rate;
                        phase_in = sw_idx ? !phase_ff : 1'b0;
                     end
                     bc = beat_ff - 7'd1;
                     beat_in = bc;
                     if (bc == 7'd0) begin
                        rsp_in.beat_flag = 1'b1;
                        beat_in = 7'(PULSES_PER_BEAT_N);
                     end
                     if (cfg.clock_mode == MODE_USE || cfg.clock_mode == MODE_GENERATE) begin
                        dc = div_ff - 8'd1;
                        div_in = dc;
                        if (dc == 8'd0) begin
                           div_in = cfg.clock_divisor;
                           if (!cfg.bypass_on) rsp_in.send_message = MSG_CLOCK;
                        end
                     end
                  end
               end
               rsp_in.run_state = run_in;
               rsp_in.period_estimate_us = meas_in ? eper_in : {10'd0, cfg.pulse_period_us};
               if (swing_go) begin
                  k_in   = 15'(rate) * 15'(cfg.swing_percent);
                  per_in = per_est;
                  now_in = now;
                  st_in  = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            qp_in = qp_prod[63:37];
            st_in = S_MUL2;
         end
         S_MUL2: begin
            kq_in = kq_full[31:0];
            z_in  = 22'(k_ff) * 22'(rp_full[6:0]);
            st_in = S_MUL3;
         end
         S_MUL3: begin
            due_in = now_ff + kq_ff + {5'd0, t_prod[63:37]};
            armed_in = 1'b1;
            st_in = S_DONE;
         end
         S_DONE: begin
            ov_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; target_ff <= '0; due_ff <= '0; last_ff <= '0; eper_ff <= '0;
         note_ff <= 8'd1; div_ff <= 8'd1; beat_ff <= 7'd1; phase_ff <= 1'b0;
         armed_ff <= 1'b0; seen_ff <= 1'b0; meas_ff <= 1'b0; run_ff <= 1'b0;
         pend_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; target_ff <= target_in; due_ff <= due_in; last_ff <= last_in;
         eper_ff <= eper_in; note_ff <= note_in; div_ff <= div_in; beat_ff <= beat_in;
         phase_ff <= phase_in; armed_ff <= armed_in; seen_ff <= seen_in;
         meas_ff <= meas_in; run_ff <= run_in; pend_ff <= pend_in; ov_ff <= ov_in;
      end
      rsp_ff <= rsp_in; k_ff <= k_in; per_ff <= per_in; qp_ff <= qp_in;
      kq_ff <= kq_in; z_ff <= z_in; now_ff <= now_in;
   end
endmodule

// File: hw/rtl/midi_tempo_clock_engine_top.sv
// MIDI tempo clock engine: top level with config registers and assertions.
// Usage:
//   req channel carries one beat per event (tick, external pulse, start, stop,
//   continue) with a microsecond timestamp; rsp channel returns exactly one
//   beat per request with pulse/note/beat flags, message and period estimate.
//   csr port: write registers only while the block is idle; the block does not enforce it.
// Sequence: a request goes from S_IDLE through S_DONE to the output register;
//   a swing-delayed note first runs the rate*period*percent/100 sequence (S_MUL1-3).
// Flow: the back end takes a new item only in S_IDLE, once the last one is done;
//   the front queue holds two requests so the sender can run ahead.
// Reset: synchronous, active high; the clock is stopped, registers return to
//   generate mode, 20833 us period, note speed 4, no swing, divisor 1.
// Stall: when rsp_ready is low the result holds in the output register, the
//   back end stops and the front queue fills, then req_ready drops.
module midi_tempo_clock_engine_top import mtce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mtce_req_if.sink    req,
   mtce_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_wdata
);
   cfg_type cfg_ff;
   job_type job;
   logic    job_valid, job_ready;
   rsp_type out;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_mode      <= MODE_GENERATE;
         cfg_ff.bypass_on       <= 1'b0;
         cfg_ff.pulse_period_us <= PERIOD_RESET;
         cfg_ff.note_speed      <= 4'd4;
         cfg_ff.swing_percent   <= 7'd0;
         cfg_ff.clock_divisor   <= 8'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:    cfg_ff.clock_mode      <= csr_wdata[2:0];
            CSR_BYPASS:  cfg_ff.bypass_on       <= csr_wdata[0];
            CSR_PERIOD:  cfg_ff.pulse_period_us <= csr_wdata;
            CSR_SPEED:   cfg_ff.note_speed      <= csr_wdata[3:0];
            CSR_SWING:   cfg_ff.swing_percent   <= csr_wdata[6:0];
            CSR_DIVISOR: cfg_ff.clock_divisor   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   mtce_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_action(req.action),
      .in_now_us(req.now_us), .in_button(req.from_button),
      .job_valid, .job_ready, .job
   );

   mtce_back u_back (
      .clock, .reset, .cfg(cfg_ff),
      .job_valid, .job_ready, .job,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out
   );

   assign rsp.pulse_flag         = out.pulse_flag;
   assign rsp.note_pulse_flag    = out.note_pulse_flag;
   assign rsp.beat_flag          = out.beat_flag;
   assign rsp.send_message       = out.send_message;
   assign rsp.accepted           = out.accepted;
   assign rsp.run_state          = out.run_state;
   assign rsp.period_estimate_us = out.period_estimate_us;

   a_pulse_on_tick_only: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.pulse_flag |-> rsp.send_message == MSG_NONE
         || rsp.send_message == MSG_CLOCK)
      else $error("pulse response carries a transport message");
   a_clock_msg_needs_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.send_message == MSG_CLOCK |-> rsp.pulse_flag)
      else $error("clock message without a pulse");
   a_beat_needs_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.beat_flag |-> rsp.pulse_flag)
      else $error("beat without a pulse");
   a_no_job_while_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !job_ready)
      else $error("back end took a job while output stalled");
endmodule
